FILE: hdl/limited_slip_differential_torque_split_top_macros.svh
// Assertion macros used by the checker of the torque split block.
// The enclosing module must provide clk_i and rst_ni.
`ifndef LIMITED_SLIP_DIFFERENTIAL_TORQUE_SPLIT_TOP_MACROS_SVH
`define LIMITED_SLIP_DIFFERENTIAL_TORQUE_SPLIT_TOP_MACROS_SVH

// Same-cycle implication.
`define LSD_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define LSD_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

FILE: hdl/lsd_pkg.sv
// ---------------------------------------------------------------------------
// lsd_pkg
// Types, constants and helper functions of the limited-slip torque split.
// ---------------------------------------------------------------------------
package lsd_pkg;

  localparam int unsigned SMOOTH_STIFFNESS = 655360;
  localparam int unsigned CORDIC_STEPS     = 17;
  localparam int unsigned Q_ONE            = 65536;

  localparam logic signed [27:0] SMOOTH_S = 28'(SMOOTH_STIFFNESS);
  localparam logic signed [67:0] S32_MAX  = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN  = -68'sd2147483648;

  typedef enum logic [3:0] {
    CFG_MOTOR_RATIO        = 4'd0,
    CFG_AXLE_GAIN          = 4'd1,
    CFG_VISCOUS_COEFF      = 4'd2,
    CFG_COULOMB_LEVEL      = 4'd3,
    CFG_PRELOAD_TORQUE     = 4'd4,
    CFG_DRIVE_RAMP         = 4'd5,
    CFG_COAST_RAMP         = 4'd6,
    CFG_COUPLING_STIFFNESS = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0] motor_ratio;
    logic [31:0] axle_gain;
    logic [31:0] viscous_coeff;
    logic [31:0] coulomb_level;
    logic [31:0] preload_torque;
    logic [19:0] drive_ramp;
    logic [19:0] coast_ramp;
    logic [31:0] coupling_stiffness;
  } cfg_t;

  // Values that ride along the arctangent pipeline.
  typedef struct packed {
    logic signed [31:0] torque;
    logic signed [31:0] visc;
    logic               sat;
    logic               dneg;
    logic [49:0]        tmag;
    logic               neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [42:0] mag;
  } front_t;

  typedef struct packed {
    side_t              side;
    logic signed [18:0] z;
  } cord_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               flag;
  } sat_t;

  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t r;
    r.val  = v[31:0];
    r.flag = 1'b0;
    if (v > S32_MAX) begin
      r.val  = 32'h7FFF_FFFF;
      r.flag = 1'b1;
    end else if (v < S32_MIN) begin
      r.val  = 32'h8000_0000;
      r.flag = 1'b1;
    end
    return r;
  endfunction

  // Angles in units of (pi/2)/65536.
  function automatic logic signed [18:0] cordic_angle(input logic [4:0] i);
    logic signed [18:0] a;
    unique case (i)
      5'd0:  a = 19'sd32768;
      5'd1:  a = 19'sd19344;
      5'd2:  a = 19'sd10221;
      5'd3:  a = 19'sd5188;
      5'd4:  a = 19'sd2604;
      5'd5:  a = 19'sd1303;
      5'd6:  a = 19'sd652;
      5'd7:  a = 19'sd326;
      5'd8:  a = 19'sd163;
      5'd9:  a = 19'sd81;
      5'd10: a = 19'sd41;
      5'd11: a = 19'sd20;
      5'd12: a = 19'sd10;
      5'd13: a = 19'sd5;
      5'd14: a = 19'sd3;
      5'd15: a = 19'sd1;
      5'd16: a = 19'sd1;
      default: a = 19'sd0;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/lsd_front.sv
// ---------------------------------------------------------------------------
// lsd_front
// Motor speed, viscous drag, smoothing argument and coupling magnitude.
// ---------------------------------------------------------------------------
module lsd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  motor_torque_i,
  input  logic signed [31:0]  left_speed_i,
  input  logic signed [31:0]  right_speed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lsd_pkg::front_t     out_o
);

  logic [4:0] v_q;
  logic [5:0] adv;

  assign adv[5] = out_ready_i;
  always_comb begin
    for (int k = 4; k >= 0; k--) adv[k] = !v_q[k] || adv[k+1];
  end
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 5; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: mean speed, speed difference and fade.
  logic [31:0] labs, rabs;
  logic [32:0] abs_sum;
  logic signed [32:0] sum0;
  logic signed [31:0] s0_mean_q, s0_torque_q;
  logic signed [32:0] s0_diff_q;
  logic [16:0] s0_fade_q;

  assign labs    = left_speed_i[31] ? (~left_speed_i + 32'd1) : left_speed_i;
  assign rabs    = right_speed_i[31] ? (~right_speed_i + 32'd1) : right_speed_i;
  assign abs_sum = 33'(labs) + 33'(rabs);
  assign sum0    = 33'(left_speed_i) + 33'(right_speed_i);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_mean_q   <= sum0[32:1];
      s0_diff_q   <= 33'(left_speed_i) - 33'(right_speed_i);
      s0_fade_q   <= (abs_sum > 33'(lsd_pkg::Q_ONE)) ? 17'(lsd_pkg::Q_ONE) : abs_sum[16:0];
      s0_torque_q <= motor_torque_i;
    end
  end

  // Stage 1: motor speed product and faded difference product.
  logic signed [64:0] s1_wprod_q;
  logic signed [50:0] s1_dprod_q;
  logic signed [31:0] s1_torque_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_wprod_q  <= s0_mean_q * $signed({1'b0, cfg_i.motor_ratio});
      s1_dprod_q  <= s0_diff_q * $signed({1'b0, s0_fade_q});
      s1_torque_q <= s0_torque_q;
    end
  end

  // Stage 2: saturate motor speed, take the coupling difference apart.
  lsd_pkg::sat_t omega;
  logic signed [50:0] dsh;
  logic signed [31:0] s2_omega_q, s2_torque_q;
  logic s2_sat_q, s2_dneg_q;
  logic [33:0] s2_dmag_q;

  assign omega = lsd_pkg::sat32(68'(s1_wprod_q >>> 16));
  assign dsh   = s1_dprod_q >>> 16;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_omega_q  <= omega.val;
      s2_sat_q    <= omega.flag;
      s2_dneg_q   <= dsh[50];
      s2_dmag_q   <= dsh[50] ? 34'(-dsh) : 34'(dsh);
      s2_torque_q <= s1_torque_q;
    end
  end

  // Stage 3: drag product, smoothing argument, coupling partial products.
  logic signed [59:0] sxprod;
  logic signed [64:0] s3_vprod_q;
  logic signed [43:0] s3_sx_q;
  logic [63:0] s3_plo_q;
  logic [33:0] s3_phi_q;
  logic signed [31:0] s3_torque_q;
  logic s3_sat_q, s3_dneg_q;

  assign sxprod = s2_omega_q * lsd_pkg::SMOOTH_S;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_vprod_q  <= s2_omega_q * $signed({1'b0, cfg_i.viscous_coeff});
      s3_sx_q     <= 44'(sxprod >>> 16);
      s3_plo_q    <= cfg_i.coupling_stiffness * s2_dmag_q[31:0];
      s3_phi_q    <= cfg_i.coupling_stiffness * s2_dmag_q[33:32];
      s3_torque_q <= s2_torque_q;
      s3_sat_q    <= s2_sat_q;
      s3_dneg_q   <= s2_dneg_q;
    end
  end

  // Stage 4: saturate drag, finish the coupling product.
  lsd_pkg::sat_t visc;
  logic [65:0] tsum;
  logic signed [43:0] sx_neg_val;
  lsd_pkg::front_t s4_q;

  assign visc       = lsd_pkg::sat32(68'(s3_vprod_q >>> 16));
  assign tsum       = {2'b00, s3_plo_q} + {s3_phi_q, 32'h0};
  assign sx_neg_val = -s3_sx_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_q.side.torque <= s3_torque_q;
      s4_q.side.visc   <= visc.val;
      s4_q.side.sat    <= s3_sat_q | visc.flag;
      s4_q.side.dneg   <= s3_dneg_q;
      s4_q.side.tmag   <= tsum[65:16];
      s4_q.side.neg    <= s3_sx_q[43];
      s4_q.mag         <= s3_sx_q[43] ? sx_neg_val[42:0] : s3_sx_q[42:0];
    end
  end

  assign out_o = s4_q;

endmodule

FILE: hdl/lsd_cordic.sv
// ---------------------------------------------------------------------------
// lsd_cordic
// Vectoring CORDIC, one micro-rotation per pipeline stage.
// ---------------------------------------------------------------------------
module lsd_cordic (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lsd_pkg::front_t  in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lsd_pkg::cord_t   out_o
);

  localparam int unsigned N = lsd_pkg::CORDIC_STEPS;

  logic               v_q    [N];
  logic signed [45:0] cx_q   [N];
  logic signed [45:0] cy_q   [N];
  logic signed [18:0] z_q    [N];
  lsd_pkg::side_t     side_q [N];
  logic [N:0]         adv;

  assign adv[N]     = out_ready_i;
  assign in_ready_o = adv[0];

  for (genvar g = 0; g < N; g++) begin : g_step
    logic signed [45:0] xi, yi, xn, yn;
    logic signed [18:0] zi, zn, ang;
    lsd_pkg::side_t     si;
    logic               vi;

    if (g == 0) begin : g_first
      assign xi = 46'(lsd_pkg::Q_ONE);
      assign yi = $signed({3'b000, in_i.mag});
      assign zi = '0;
      assign si = in_i.side;
      assign vi = in_valid_i;
    end else begin : g_next
      assign xi = cx_q[g-1];
      assign yi = cy_q[g-1];
      assign zi = z_q[g-1];
      assign si = side_q[g-1];
      assign vi = v_q[g-1];
    end

    assign ang    = lsd_pkg::cordic_angle(5'(g));
    assign adv[g] = !v_q[g] || adv[g+1];

    // A zero y leaves the vector as it is.
    always_comb begin
      xn = xi;
      yn = yi;
      zn = zi;
      if (yi > 46'sd0) begin
        xn = xi + (yi >>> g);
        yn = yi - (xi >>> g);
        zn = zi + ang;
      end else if (yi < 46'sd0) begin
        xn = xi - (yi >>> g);
        yn = yi + (xi >>> g);
        zn = zi - ang;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (adv[g]) begin
        v_q[g] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[g]) begin
        cx_q[g]   <= xn;
        cy_q[g]   <= yn;
        z_q[g]    <= zn;
        side_q[g] <= si;
      end
    end
  end

  assign out_valid_o = v_q[N-1];
  assign out_o.side  = side_q[N-1];
  assign out_o.z     = z_q[N-1];

endmodule

FILE: hdl/lsd_back.sv
// ---------------------------------------------------------------------------
// lsd_back
// Coulomb drag, axle torque, locking limit, clamp and wheel split.
// ---------------------------------------------------------------------------
module lsd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lsd_pkg::cord_t      in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  left_torque_o,
  output logic signed [31:0]  right_torque_o,
  output logic                saturated_o
);

  logic [6:0] v_q;
  logic [7:0] adv;

  assign adv[7] = out_ready_i;
  always_comb begin
    for (int k = 6; k >= 0; k--) adv[k] = !v_q[k] || adv[k+1];
  end
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 7; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Stage 0: clamp the angle sum, apply the sign, Coulomb product.
  logic signed [17:0] zc, sgn;
  logic signed [50:0] b0_cprod_q;
  lsd_pkg::side_t b0_side_q;

  always_comb begin
    if (in_i.z < 19'sd0) zc = '0;
    else if (in_i.z > 19'sd65536) zc = 18'sd65536;
    else zc = in_i.z[17:0];
    sgn = in_i.side.neg ? -zc : zc;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      b0_cprod_q <= sgn * $signed({1'b0, cfg_i.coulomb_level});
      b0_side_q  <= in_i.side;
    end
  end

  // Stage 1: Coulomb drag and shaft torque.
  lsd_pkg::sat_t coul, shaft;
  logic signed [33:0] shaft_raw;
  logic signed [31:0] b1_shaft_q;
  logic b1_sat_q, b1_dneg_q;
  logic [49:0] b1_tmag_q;

  assign coul      = lsd_pkg::sat32(68'(b0_cprod_q >>> 16));
  assign shaft_raw = 34'(b0_side_q.torque) - 34'(b0_side_q.visc) - 34'(coul.val);
  assign shaft     = lsd_pkg::sat32(68'(shaft_raw));

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      b1_shaft_q <= shaft.val;
      b1_sat_q   <= b0_side_q.sat | coul.flag | shaft.flag;
      b1_dneg_q  <= b0_side_q.dneg;
      b1_tmag_q  <= b0_side_q.tmag;
    end
  end

  // Stage 2: axle torque product.
  logic signed [64:0] b2_aprod_q;
  logic b2_sat_q, b2_dneg_q;
  logic [49:0] b2_tmag_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      b2_aprod_q <= b1_shaft_q * $signed({1'b0, cfg_i.axle_gain});
      b2_sat_q   <= b1_sat_q;
      b2_dneg_q  <= b1_dneg_q;
      b2_tmag_q  <= b1_tmag_q;
    end
  end

  // Stage 3: saturate axle torque.
  lsd_pkg::sat_t axle;
  logic signed [31:0] b3_axle_q;
  logic b3_sat_q, b3_dneg_q;
  logic [49:0] b3_tmag_q;

  assign axle = lsd_pkg::sat32(68'(b2_aprod_q >>> 16));

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      b3_axle_q <= axle.val;
      b3_sat_q  <= b2_sat_q | axle.flag;
      b3_dneg_q <= b2_dneg_q;
      b3_tmag_q <= b2_tmag_q;
    end
  end

  // Stage 4: ramp share of the absolute axle torque.
  logic [31:0] aabs;
  logic [19:0] ramp;
  logic [51:0] b4_lprod_q;
  logic signed [31:0] b4_half_q;
  logic b4_sat_q, b4_dneg_q;
  logic [49:0] b4_tmag_q;

  assign aabs = b3_axle_q[31] ? (~b3_axle_q + 32'd1) : b3_axle_q;
  assign ramp = (!b3_axle_q[31] && (b3_axle_q != 32'sd0)) ? cfg_i.drive_ramp
                                                          : cfg_i.coast_ramp;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      b4_lprod_q <= ramp * aabs;
      b4_half_q  <= b3_axle_q >>> 1;
      b4_sat_q   <= b3_sat_q;
      b4_dneg_q  <= b3_dneg_q;
      b4_tmag_q  <= b3_tmag_q;
    end
  end

  // Stage 5: locking limit and clamp of the coupling torque.
  logic [35:0] limit, tm;
  logic signed [36:0] b5_tau_q;
  logic signed [31:0] b5_half_q;
  logic b5_sat_q;

  assign limit = 36'(cfg_i.preload_torque) + b4_lprod_q[51:16];
  assign tm    = (b4_tmag_q > 50'(limit)) ? limit : b4_tmag_q[35:0];

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      b5_tau_q  <= b4_dneg_q ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
      b5_half_q <= b4_half_q;
      b5_sat_q  <= b4_sat_q;
    end
  end

  // Stage 6: output register.
  lsd_pkg::sat_t lt, rt;
  logic signed [31:0] b6_lt_q, b6_rt_q;
  logic b6_sat_q;

  assign lt = lsd_pkg::sat32(68'(b5_half_q) - 68'(b5_tau_q));
  assign rt = lsd_pkg::sat32(68'(b5_half_q) + 68'(b5_tau_q));

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      b6_lt_q  <= lt.val;
      b6_rt_q  <= rt.val;
      b6_sat_q <= b5_sat_q | lt.flag | rt.flag;
    end
  end

  assign left_torque_o  = b6_lt_q;
  assign right_torque_o = b6_rt_q;
  assign saturated_o    = b6_sat_q;

endmodule

FILE: hdl/limited_slip_differential_torque_split_top.sv
// ---------------------------------------------------------------------------
// limited_slip_differential_torque_split_top
// Rear wheel torque split of a ramp-type limited-slip differential.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  cfg     | in        | cfg_valid/ready    | cfg_index_i, cfg_data_i
//  in      | in        | in_valid/ready     | motor_torque, left/right_speed
//  out     | out       | out_valid/ready    | left/right_torque, saturated
//
// One beat enters per cycle while in_ready_o is high; each beat passes through
// 29 register stages (5 front, 17 CORDIC, 7 back) before its result is offered.
// Every stage advances when it is empty or its successor advances, so a
// stalled output fills bubbles before in_ready_o drops.
// Reset empties the pipeline and loads the register reset values.
// ---------------------------------------------------------------------------
module limited_slip_differential_torque_split_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [31:0]  motor_torque_i,
  input  logic signed [31:0]  left_speed_i,
  input  logic signed [31:0]  right_speed_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  left_torque_o,
  output logic signed [31:0]  right_torque_o,
  output logic                saturated_o
);

  lsd_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.motor_ratio        <= 32'(lsd_pkg::Q_ONE);
      cfg_q.axle_gain          <= 32'(lsd_pkg::Q_ONE);
      cfg_q.viscous_coeff      <= '0;
      cfg_q.coulomb_level      <= '0;
      cfg_q.preload_torque     <= '0;
      cfg_q.drive_ramp         <= '0;
      cfg_q.coast_ramp         <= '0;
      cfg_q.coupling_stiffness <= '0;
    end else if (cfg_valid_i) begin
      unique case (lsd_pkg::cfg_idx_e'(cfg_index_i))
        lsd_pkg::CFG_MOTOR_RATIO:        cfg_q.motor_ratio        <= cfg_data_i;
        lsd_pkg::CFG_AXLE_GAIN:          cfg_q.axle_gain          <= cfg_data_i;
        lsd_pkg::CFG_VISCOUS_COEFF:      cfg_q.viscous_coeff      <= cfg_data_i;
        lsd_pkg::CFG_COULOMB_LEVEL:      cfg_q.coulomb_level      <= cfg_data_i;
        lsd_pkg::CFG_PRELOAD_TORQUE:     cfg_q.preload_torque     <= cfg_data_i;
        lsd_pkg::CFG_DRIVE_RAMP:         cfg_q.drive_ramp         <= cfg_data_i[19:0];
        lsd_pkg::CFG_COAST_RAMP:         cfg_q.coast_ramp         <= cfg_data_i[19:0];
        lsd_pkg::CFG_COUPLING_STIFFNESS: cfg_q.coupling_stiffness <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic            f_valid, f_ready, c_valid, c_ready;
  lsd_pkg::front_t f_data;
  lsd_pkg::cord_t  c_data;

  lsd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .motor_torque_i (motor_torque_i),
    .left_speed_i   (left_speed_i),
    .right_speed_i  (right_speed_i),
    .out_valid_o    (f_valid),
    .out_ready_i    (f_ready),
    .out_o          (f_data)
  );

  lsd_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_i        (f_data),
    .out_valid_o (c_valid),
    .out_ready_i (c_ready),
    .out_o       (c_data)
  );

  lsd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .in_valid_i     (c_valid),
    .in_ready_o     (c_ready),
    .in_i           (c_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_torque_o  (left_torque_o),
    .right_torque_o (right_torque_o),
    .saturated_o    (saturated_o)
  );

endmodule

FILE: hdl/lsd_checker.sv
// ---------------------------------------------------------------------------
// lsd_checker
// Port-level checks of the torque split block, bound to the top level.
// ---------------------------------------------------------------------------
`include "limited_slip_differential_torque_split_top_macros.svh"

module lsd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [3:0]         cfg_index_i,
  input logic [31:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [31:0] motor_torque_i,
  input logic signed [31:0] left_speed_i,
  input logic signed [31:0] right_speed_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] left_torque_o,
  input logic signed [31:0] right_torque_o,
  input logic               saturated_o
);

  // A stalled result beat holds.
  `LSD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(left_torque_o) && $stable(right_torque_o) && $stable(saturated_o))

  // The input side only blocks when every stage is full and the output stalls.
  `LSD_ASSERT_IMPL(a_full_only, !in_ready_o, out_valid_o && !out_ready_i)

  // A taken output frees room for the next input beat.
  `LSD_ASSERT_IMPL(a_drain_ready, out_ready_i, in_ready_o)

  // Register writes are never refused.
  `LSD_ASSERT_IMPL(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind limited_slip_differential_torque_split_top lsd_checker u_lsd_checker (.*);
